>>> rtl/spr_pkg.sv
package spr_pkg;

  // field and state widths
  localparam int POS_W      = 24;
  localparam int DIFF_W     = POS_W + 1;
  localparam int SUM_W      = 28;
  localparam int CNT_W      = 4;
  localparam int RAD_W      = 23;
  localparam int SQ_W       = 2 * POS_W + 1;
  localparam int MAX_WINDOW = 8;

  // mean divider: radix-16 restoring, one digit per cycle
  localparam int DIG_BITS   = 4;
  localparam int DIV_ITER   = SUM_W / DIG_BITS;
  localparam int ITER_W     = $clog2(DIV_ITER);

  // port widths
  localparam int IN_TDATA_W  = 2 * POS_W;
  localparam int OUT_TDATA_W = 2 * POS_W;
  localparam int OC_W        = 3;
  localparam int OUT_TUSER_W = 1 + OC_W;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = RAD_W;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STRIKE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = 2'd2;

  // configuration reset values
  localparam logic [RAD_W-1:0] RADIUS_RST = 23'd16384;
  localparam logic [CNT_W-1:0] STRIKE_RST = 4'd3;
  localparam logic [CNT_W-1:0] WINDOW_RST = 4'd8;

  // per-item outcome codes
  typedef enum logic [OC_W-1:0] {
    OC_REPEAT     = 3'd0,
    OC_STRIKE_CLR = 3'd1,
    OC_START      = 3'd2,
    OC_RECAL      = 3'd3,
    OC_OUTLIER    = 3'd4,
    OC_ACCEPT     = 3'd5
  } outcome_t;

endpackage

>>> rtl/stationary_position_recalibrator_unit.sv
// channel   dir  beat fields (lowest bits first)
// in_*      in   tdata: pos_x[23:0], pos_y[47:24]
// out_*     out  tdata: mean_x[23:0], mean_y[47:24]; tuser: recalibrate[0], outcome[3:1]
// cfg_*     in   cfg_addr 0 radius_max, 1 strike_limit, 2 window_target
//
// repeat, strike clear, window start and recalibration go from accept through the decision
// to the done state; an outlier also runs the three squares and the compare, and an
// accepted sample also runs the radix-16 mean divider once per axis;
// the distance check runs three squares through one 25x25 multiplier.
// rst_n is synchronous; after reset the window holds one zero sample.
// a finished result waits in the output register while the next beat is taken;
// a new result waits in its final state only while that register is still full.
module stationary_position_recalibrator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [spr_pkg::IN_TDATA_W-1:0]     in_tdata,   // pos_x, pos_y
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [spr_pkg::OUT_TDATA_W-1:0]    out_tdata,  // mean_x, mean_y
  output logic [spr_pkg::OUT_TUSER_W-1:0]    out_tuser,  // recalibrate, outcome
  input  logic                               cfg_we,
  input  logic [spr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [spr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import spr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_MUL_X, S_MUL_Y, S_MUL_R, S_CMP, S_LOAD, S_DIV, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [RAD_W-1:0] radius_r;
  logic [CNT_W-1:0] strike_lim_r;
  logic [CNT_W-1:0] win_tgt_r;

  // window state
  logic [POS_W-1:0] last_x_r, last_y_r;
  logic [POS_W-1:0] avg_x_r, avg_y_r;
  logic [SUM_W-1:0] sum_x_r, sum_y_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] strikes_r;

  // item in flight
  logic [POS_W-1:0]  in_x_r, in_y_r;
  logic [DIFF_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]   prod_r;
  logic [SQ_W:0]     acc_r;

  // divider
  logic [SUM_W-1:0]  num_r;
  logic [CNT_W-1:0]  rem_r;
  logic              neg_r;
  logic [ITER_W-1:0] iter_r;
  logic              axis_r;

  // result
  logic              res_rec_r;
  outcome_t          res_oc_r;
  logic [POS_W-1:0]  res_mx_r, res_my_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;

  // decision terms
  logic [CNT_W-1:0] target_eff;
  logic             is_repeat;
  logic [SUM_W-1:0] sum_x_new, sum_y_new;

  assign target_eff = (win_tgt_r > CNT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : win_tgt_r;
  assign is_repeat  = (in_x_r == last_x_r) && (in_y_r == last_y_r);
  assign sum_x_new  = sum_x_r + {{(SUM_W-POS_W){in_x_r[POS_W-1]}}, in_x_r};
  assign sum_y_new  = sum_y_r + {{(SUM_W-POS_W){in_y_r[POS_W-1]}}, in_y_r};

  // shared squaring multiplier
  logic signed [DIFF_W-1:0]   mul_op;
  logic signed [2*DIFF_W-1:0] mul_full;
  logic [SQ_W-1:0]            mul_sq;

  always_comb begin
    case (state_r)
      S_MUL_X: mul_op = $signed(dx_r);
      S_MUL_Y: mul_op = $signed(dy_r);
      default: mul_op = $signed({{(DIFF_W-RAD_W){1'b0}}, radius_r});
    endcase
  end

  assign mul_full = mul_op * mul_op;
  assign mul_sq   = mul_full[SQ_W-1:0];

  // divider operand load: magnitude of the sum plus half the count
  logic [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0] sum_mag;
  logic [SUM_W-1:0] num_load;

  assign sum_sel  = axis_r ? sum_y_r : sum_x_r;
  assign sum_mag  = sum_sel[SUM_W-1] ? (~sum_sel + SUM_W'(1)) : sum_sel;
  assign num_load = sum_mag + {{(SUM_W-CNT_W+1){1'b0}}, count_r[CNT_W-1:1]};

  // one radix-16 digit of restoring division by the count
  logic [SUM_W-1:0] num_step;
  logic [CNT_W-1:0] rem_step;

  always_comb begin
    logic [CNT_W:0]   trial;
    logic [SUM_W-1:0] n;
    logic [CNT_W-1:0] r;
    n = num_r;
    r = rem_r;
    for (int i = 0; i < DIG_BITS; i++) begin
      trial = {r, n[SUM_W-1]};
      n     = {n[SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, count_r}) begin
        r    = CNT_W'(trial - {1'b0, count_r});
        n[0] = 1'b1;
      end else begin
        r    = trial[CNT_W-1:0];
      end
    end
    num_step = n;
    rem_step = r;
  end

  logic [POS_W-1:0] quot;
  logic [POS_W-1:0] mean_new;

  assign quot     = num_step[POS_W-1:0];
  assign mean_new = neg_r ? (~quot + POS_W'(1)) : quot;

  // sequencer, window state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      radius_r     <= RADIUS_RST;
      strike_lim_r <= STRIKE_RST;
      win_tgt_r    <= WINDOW_RST;
      last_x_r     <= '0;
      last_y_r     <= '0;
      avg_x_r      <= '0;
      avg_y_r      <= '0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      count_r      <= CNT_W'(1);
      strikes_r    <= '0;
      axis_r       <= 1'b0;
      iter_r       <= '0;
      res_rec_r    <= 1'b0;
      res_oc_r     <= OC_REPEAT;
      out_valid_r  <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_RADIUS: radius_r     <= cfg_wdata;
          REG_STRIKE: strike_lim_r <= cfg_wdata[CNT_W-1:0];
          REG_WINDOW: win_tgt_r    <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end

      // output register: load a finished result or drop a taken beat
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            in_x_r    <= in_tdata[POS_W-1:0];
            in_y_r    <= in_tdata[2*POS_W-1:POS_W];
            res_rec_r <= 1'b0;
            state_r   <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (is_repeat) begin
            res_oc_r <= OC_REPEAT;
            state_r  <= S_DONE;
          end else if (strikes_r >= strike_lim_r) begin
            avg_x_r   <= '0;
            avg_y_r   <= '0;
            sum_x_r   <= '0;
            sum_y_r   <= '0;
            count_r   <= '0;
            strikes_r <= '0;
            res_oc_r  <= OC_STRIKE_CLR;
            state_r   <= S_DONE;
          end else if (count_r == '0) begin
            avg_x_r  <= in_x_r;
            avg_y_r  <= in_y_r;
            sum_x_r  <= {{(SUM_W-POS_W){in_x_r[POS_W-1]}}, in_x_r};
            sum_y_r  <= {{(SUM_W-POS_W){in_y_r[POS_W-1]}}, in_y_r};
            count_r  <= CNT_W'(1);
            last_x_r <= in_x_r;
            last_y_r <= in_y_r;
            res_oc_r <= OC_START;
            state_r  <= S_DONE;
          end else if (count_r >= target_eff) begin
            res_rec_r <= 1'b1;
            res_mx_r  <= avg_x_r;
            res_my_r  <= avg_y_r;
            avg_x_r   <= '0;
            avg_y_r   <= '0;
            sum_x_r   <= '0;
            sum_y_r   <= '0;
            count_r   <= '0;
            last_x_r  <= in_x_r;
            last_y_r  <= in_y_r;
            res_oc_r  <= OC_RECAL;
            state_r   <= S_DONE;
          end else begin
            dx_r    <= {in_x_r[POS_W-1], in_x_r} - {avg_x_r[POS_W-1], avg_x_r};
            dy_r    <= {in_y_r[POS_W-1], in_y_r} - {avg_y_r[POS_W-1], avg_y_r};
            state_r <= S_MUL_X;
          end
        end

        // dx^2, then dy^2, then radius^2 through the one multiplier
        S_MUL_X: begin
          prod_r  <= mul_sq;
          state_r <= S_MUL_Y;
        end

        S_MUL_Y: begin
          acc_r   <= {1'b0, prod_r};
          prod_r  <= mul_sq;
          state_r <= S_MUL_R;
        end

        S_MUL_R: begin
          acc_r   <= acc_r + {1'b0, prod_r};
          prod_r  <= mul_sq;
          state_r <= S_CMP;
        end

        S_CMP: begin
          last_x_r <= in_x_r;
          last_y_r <= in_y_r;
          if (acc_r > {1'b0, prod_r}) begin
            if (strikes_r != '1) begin
              strikes_r <= strikes_r + CNT_W'(1);
            end
            res_oc_r <= OC_OUTLIER;
            state_r  <= S_DONE;
          end else begin
            sum_x_r <= sum_x_new;
            sum_y_r <= sum_y_new;
            if (count_r != '1) begin
              count_r <= count_r + CNT_W'(1);
            end
            axis_r   <= 1'b0;
            res_oc_r <= OC_ACCEPT;
            state_r  <= S_LOAD;
          end
        end

        S_LOAD: begin
          num_r   <= num_load;
          rem_r   <= '0;
          neg_r   <= sum_sel[SUM_W-1];
          iter_r  <= '0;
          state_r <= S_DIV;
        end

        S_DIV: begin
          num_r  <= num_step;
          rem_r  <= rem_step;
          iter_r <= iter_r + ITER_W'(1);
          if (iter_r == ITER_W'(DIV_ITER - 1)) begin
            if (!axis_r) begin
              avg_x_r <= mean_new;
              axis_r  <= 1'b1;
              state_r <= S_LOAD;
            end else begin
              avg_y_r <= mean_new;
              state_r <= S_DONE;
            end
          end
        end

        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_tdata_r <= res_rec_r ? {res_my_r, res_mx_r} : {avg_y_r, avg_x_r};
            out_tuser_r <= {res_oc_r, res_rec_r};
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

>>> rtl/spr_checker.sv
module spr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [spr_pkg::OUT_TDATA_W-1:0]    out_tdata,  // mean_x, mean_y
  input logic [spr_pkg::OUT_TUSER_W-1:0]    out_tuser   // recalibrate, outcome
);
  import spr_pkg::*;

  // a stalled result beat holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // the recalibrate flag goes with the recalibrated outcome only
  a_rec_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[0] == (out_tuser[OUT_TUSER_W-1:1] == OC_RECAL))
    else $error("recalibrate flag disagrees with outcome");

  // a strike clear leaves an empty window with zero mean
  a_clr_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[OUT_TUSER_W-1:1] == OC_STRIKE_CLR |-> out_tdata == '0)
    else $error("nonzero mean after strike clear");

  // one item at a time: busy right after a beat is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

endmodule

bind stationary_position_recalibrator_unit spr_checker u_spr_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import spr_pkg::*;

  // one result beat as the block should present it
  typedef struct packed {
    logic        recal;
    logic [23:0] mean_x;
    logic [23:0] mean_y;
    outcome_t    outcome;
  } recal_beat_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;     // pos_x, pos_y
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // mean_x, mean_y
  logic [OUT_TUSER_W-1:0] out_tuser;   // recalibrate, outcome
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predicted tracker state and register copies
  logic signed [23:0] trk_last_x, trk_last_y, trk_avg_x, trk_avg_y;
  longint trk_sum_x, trk_sum_y;
  int trk_count, trk_strikes;
  logic [RAD_W-1:0] trk_radius;
  logic [3:0] trk_strike_lim, trk_window;

  recal_beat_t pending_outcomes[$];
  int mismatches;
  bit idle_on;
  int hold_left;
  logic signed [23:0] sent_x, sent_y;

  stationary_position_recalibrator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("tb NOT OK");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [23:0] clamp24(input int v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // any coordinate, with extra weight on the extremes
  function automatic int pick_coord();
    int r;
    logic [23:0] raw;
    r = $urandom_range(0, 99);
    raw = 24'($urandom());
    if (r < 10) return -8388608;
    if (r < 20) return 8388607;
    return int'($signed(raw));
  endfunction

  // mean of the window: round to nearest, ties away from zero
  function automatic logic signed [23:0] round_mean(input longint s, input int c);
    longint mag, q;
    mag = (s < 0) ? -s : s;
    if (c == 0) c = 1;
    q = (mag + c / 2) / c;
    return (s < 0) ? 24'(-q) : 24'(q);
  endfunction

  function automatic void clear_window();
    trk_avg_x = '0;
    trk_avg_y = '0;
    trk_sum_x = 0;
    trk_sum_y = 0;
    trk_count = 0;
  endfunction

  // advance the predicted state by one position and return the beat it owes
  function automatic recal_beat_t apply_position(input logic signed [23:0] px,
                                                 input logic signed [23:0] py);
    recal_beat_t r;
    int tgt;
    longint dx, dy, d2, r2;
    tgt = (trk_window > MAX_WINDOW) ? MAX_WINDOW : int'(trk_window);
    r.recal = 1'b0;
    if (px == trk_last_x && py == trk_last_y) begin
      r.outcome = OC_REPEAT;
    end else if (trk_strikes >= int'(trk_strike_lim)) begin
      clear_window();
      trk_strikes = 0;
      r.outcome = OC_STRIKE_CLR;
    end else if (trk_count == 0) begin
      trk_avg_x = px;
      trk_avg_y = py;
      trk_sum_x = longint'(px);
      trk_sum_y = longint'(py);
      trk_count = 1;
      trk_last_x = px;
      trk_last_y = py;
      r.outcome = OC_START;
    end else if (trk_count >= tgt) begin
      // mean leaves with the beat, then the window empties
      r.recal = 1'b1;
      r.mean_x = trk_avg_x;
      r.mean_y = trk_avg_y;
      r.outcome = OC_RECAL;
      clear_window();
      trk_last_x = px;
      trk_last_y = py;
      return r;
    end else begin
      dx = longint'(px) - longint'(trk_avg_x);
      dy = longint'(py) - longint'(trk_avg_y);
      d2 = dx * dx + dy * dy;
      r2 = longint'(trk_radius) * longint'(trk_radius);
      if (d2 > r2) begin
        if (trk_strikes < 15) trk_strikes++;
        r.outcome = OC_OUTLIER;
      end else begin
        trk_sum_x += longint'(px);
        trk_sum_y += longint'(py);
        if (trk_count < 15) trk_count++;
        trk_avg_x = round_mean(trk_sum_x, trk_count);
        trk_avg_y = round_mean(trk_sum_y, trk_count);
        r.outcome = OC_ACCEPT;
      end
      trk_last_x = px;
      trk_last_y = py;
    end
    r.mean_x = trk_avg_x;
    r.mean_y = trk_avg_y;
    return r;
  endfunction

  // one input beat; entered at a falling edge, left at a falling edge
  task automatic send_pos(input logic signed [23:0] px, input logic signed [23:0] py);
    int gap;
    in_tdata = {py, px};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_outcomes.insert(pending_outcomes.size(), apply_position(px, py));
    sent_x = px;
    sent_y = py;
    @(negedge clk);
    gap = (idle_on && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // wait until every owed beat has come back, then let the block settle
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_addr = idx;
    cfg_wdata = val;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_RADIUS: trk_radius = val;
      REG_STRIKE: trk_strike_lim = val[3:0];
      REG_WINDOW: trk_window = val[3:0];
      default: ;
    endcase
  endtask

  // upper bits of the narrow registers carry junk on purpose
  task automatic set_config(input logic [RAD_W-1:0] rad, input logic [3:0] strike,
                            input logic [3:0] win);
    drain();
    write_reg(REG_RADIUS, rad);
    write_reg(REG_STRIKE, {19'($urandom()), strike});
    write_reg(REG_WINDOW, {19'($urandom()), win});
  endtask

  // a run of positions around one spot, with repeats and wild fixes mixed in
  task automatic send_cluster(input int n, input int amp, input int p_rep, input int p_wild);
    int cx, cy, r, k;
    cx = pick_coord();
    cy = pick_coord();
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < p_rep)
        send_pos(sent_x, sent_y);
      else if (r < p_rep + p_wild)
        send_pos(clamp24(pick_coord()), clamp24(pick_coord()));
      else
        send_pos(clamp24(cx + int'($urandom_range(0, 2 * amp)) - amp),
                 clamp24(cy + int'($urandom_range(0, 2 * amp)) - amp));
    end
  endtask

  // receiver: random stalls, plus a long hold when asked
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap() - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    recal_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat tdata=%h tuser=%h", $realtime, out_tdata, out_tuser);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_tuser[0] !== want.recal || out_tuser[3:1] !== want.outcome ||
            out_tdata[23:0] !== want.mean_x || out_tdata[47:24] !== want.mean_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected rec=%0d oc=%0d mean=(%0d,%0d) got rec=%0d oc=%0d mean=(%0d,%0d)",
                     $realtime, want.recal, want.outcome, $signed(want.mean_x),
                     $signed(want.mean_y), out_tuser[0], out_tuser[3:1],
                     $signed(out_tdata[23:0]), $signed(out_tdata[47:24]));
        end
      end
    end
  end

  // fill a window, recalibrate, strike out, clear, rounding ties
  task automatic test_directed();
    int dir_x [21];
    int dir_y [21];
    int k;
    dir_x = '{0, 1, 2, -3, 4, -5, 100, -16000, 8388607, -8388608, 8388607,
              -8388608, 8388607, 8388607, 0, 0, 0, -1, 1, -8388608, 1};
    dir_y = '{0, 0, -1, 3, 4, -5, -100, 0, 8388607, -8388608, -8388608,
              8388607, 8388607, 8388607, 0, 0, 0, -1, 2, 0, -1};
    idle_on = 1'b1;
    for (k = 0; k < 21; k++) send_pos(clamp24(dir_x[k]), clamp24(dir_y[k]));
  endtask

  // register extremes, out-of-range window and zero strike limit
  task automatic test_config_extremes();
    set_config(23'd16384, 4'd0, 4'd8);
    send_cluster(12, 4096, 10, 20);
    set_config(23'd16384, 4'd3, 4'd0);
    send_cluster(12, 4096, 10, 20);
    set_config(23'd16384, 4'd3, 4'd15);
    send_cluster(20, 4096, 5, 10);
    set_config(23'd0, 4'd1, 4'd4);
    send_cluster(12, 1, 10, 20);
    set_config(23'h7FFFFF, 4'd15, 4'd1);
    send_cluster(12, 4194303, 10, 30);
    set_config(23'd65536, 4'd15, 4'd8);
    send_cluster(30, 65536, 5, 40);
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    set_config(23'd40000, 4'd4, 4'd5);
    idle_on = 1'b0;
    hold_left = 400;
    send_cluster(40, 20000, 10, 10);
    drain();
  endtask

  // random phases, each with its own register setting
  task automatic test_random();
    int ph, cnt, n, amp, rsel;
    logic [RAD_W-1:0] rad;
    for (ph = 0; ph < 8; ph++) begin
      rsel = $urandom_range(0, 5);
      case (rsel)
        0: rad = '0;
        1: rad = 23'h7FFFFF;
        2, 3: rad = 23'($urandom_range(64, 65536));
        default: rad = 23'($urandom_range(0, 8388607));
      endcase
      set_config(rad, 4'($urandom_range(0, 15)),
                 ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8)));
      idle_on = (ph % 3) != 0;
      cnt = 0;
      while (cnt < 250) begin
        n = $urandom_range(4, 24);
        amp = ($urandom_range(0, 9) < 7) ? int'(rad) / 2 : int'(rad);
        if (amp < 2) amp = 2;
        send_cluster(n, amp, 8, ($urandom_range(0, 1) != 0) ? 5 : 30);
        cnt += n;
        // sender pause until everything is back
        if ($urandom_range(0, 14) == 0) drain();
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    mismatches = 0;
    idle_on = 1'b0;
    hold_left = 0;
    sent_x = '0;
    sent_y = '0;
    trk_last_x = '0;
    trk_last_y = '0;
    trk_avg_x = '0;
    trk_avg_y = '0;
    trk_sum_x = 0;
    trk_sum_y = 0;
    trk_count = 1;
    trk_strikes = 0;
    trk_radius = RADIUS_RST;
    trk_strike_lim = STRIKE_RST;
    trk_window = WINDOW_RST;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();
    drain();

    if (mismatches == 0 && pending_outcomes.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

>>> stationary_position_recalibrator_unit.f
rtl/spr_pkg.sv
rtl/stationary_position_recalibrator_unit.sv
rtl/spr_checker.sv
test/tb.sv
